### rtl/bpyb_pkg.sv
`default_nettype none
package bpyb_pkg;

	localparam int PriceW = 48;
	localparam int YieldW = 31;
	localparam int FactW = 33;
	localparam int MaxPaymentsDef = 128;

	// 200 percent in yield format; the per-period factor is DenBase / (DenBase + y).
	localparam logic [63:0] DenBase = 64'd3355443200;
	localparam logic [YieldW-1:0] YieldFull = 31'd1677721600;

	typedef enum logic [2:0] {
		CFG_FACE   = 3'd0,
		CFG_COUPON = 3'd1,
		CFG_COUNT  = 3'd2,
		CFG_TOL    = 3'd3,
		CFG_LIMIT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PriceW-1:0] face;
		logic [PriceW-1:0] coupon;
		logic [7:0]        count;
	} price_cfg_t;

endpackage
`default_nettype wire

### rtl/bpyb_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, for the discount factor.
module bpyb_div import bpyb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [FactW-1:0] den,
	output logic                  done,
	output logic [FactW-1:0]      quot
);

	logic [63:0]      num_q;
	logic [63:0]      quo_q;
	logic [FactW-1:0] rem_q;
	logic [FactW-1:0] den_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [FactW:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == 7'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Numerator is DenBase * 2^32 plus half the divisor, for round half up.
			num_q <= {DenBase[31:0], 32'd0} + {32'd0, den[FactW-1:1]};
			rem_q <= '0;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? FactW'(trial - {1'b0, den_q}) : FactW'(trial);
		end
	end

	assign done = done_q;
	assign quot = quo_q[FactW-1:0];

endmodule
`default_nettype wire

### rtl/bpyb_price.sv
`default_nettype none
// Prices the bond at one yield with a single shared 33x33 multiplier.
module bpyb_price import bpyb_pkg::*; #(
	parameter int MAX_PAYMENTS = MaxPaymentsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [YieldW-1:0] yield_in,
	input  wire price_cfg_t        cfg,
	output logic                   done,
	output logic [PriceW-1:0]      price
);

	localparam int CntW = $clog2(MAX_PAYMENTS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_PD, S_PW, S_LO, S_HI, S_ACC, S_FIN
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   n_q;
	logic [CntW-1:0]   i_q;
	logic [CntW-1:0]   n_lim;
	logic [FactW-1:0]  d_q;
	logic [FactW-1:0]  p_q;
	logic [FactW-1:0]  t_q;
	logic [65:0]       prod_q;
	logic [63:0]       sum_q;
	logic [63:0]       rnd;
	logic [PriceW-1:0] price_q;
	logic              done_q;
	logic [FactW-1:0]  mul_a;
	logic [FactW-1:0]  mul_b;
	logic [65:0]       prod_rnd;
	logic [49:0]       cf;
	logic              div_done;
	logic [FactW-1:0]  div_quot;
	logic [FactW-1:0]  den;

	assign den = FactW'(DenBase) + FactW'(yield_in);

	bpyb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		if (int'(cfg.count) > MAX_PAYMENTS) n_lim = CntW'(MAX_PAYMENTS);
		else n_lim = CntW'(cfg.count);
	end

	// Half coupon on every period, face value added on the last one (17 fraction bits).
	assign cf = (i_q < n_q) ? {2'b0, cfg.coupon}
	                        : {1'b0, cfg.face, 1'b0} + {2'b0, cfg.coupon};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PD: begin
				mul_a = p_q;
				mul_b = d_q;
			end
			S_LO: begin
				mul_a = {1'b0, cf[31:0]};
				mul_b = p_q;
			end
			S_HI: begin
				mul_a = FactW'(cf[49:32]);
				mul_b = p_q;
			end
			default: ;
		endcase
	end

	assign prod_rnd = prod_q + 66'h8000_0000;
	assign rnd      = (sum_q + 64'd1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= (n_q == '0) ? S_FIN : S_PD;
				S_PD: state_q <= div_quot[FactW-1] ? S_LO : S_PW;
				S_PW: state_q <= S_LO;
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_ACC;
				S_ACC: state_q <= (i_q == n_q) ? S_FIN : S_PD;
				S_FIN: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: if (start) begin
				n_q   <= n_lim;
				i_q   <= CntW'(1);
				p_q   <= {1'b1, 32'd0};
				sum_q <= '0;
			end
			S_DIV: d_q <= div_quot;
			S_PW: p_q <= prod_rnd[64:32];
			S_HI: t_q <= prod_rnd[64:32];
			S_ACC: begin
				sum_q <= sum_q + prod_q[63:0] + 64'(t_q);
				i_q   <= i_q + CntW'(1);
			end
			S_FIN: price_q <= (|rnd[63:PriceW]) ? '1 : rnd[PriceW-1:0];
			default: ;
		endcase
	end

	assign done  = done_q;
	assign price = price_q;

endmodule
`default_nettype wire

### rtl/bond_price_and_yield_bisection.sv
`default_nettype none
// Semiannual bond price and yield calculator. An item with operation 0 prices the bond at
// yield_percent (percent, 24 fraction bits) and echoes that yield with status 0. An item
// with operation 1 searches 0 to 100 percent by bisection for the yield whose price
// matches market_price: both ends are tried first, then up to iteration_limit midpoints;
// a miss reports status 1 with zero price and yield. Prices carry 16 fraction bits and
// saturate at 48 bits. One price evaluation over N payments (capped at MAX_PAYMENTS) first
// forms the discount factor in the bit-serial divider, then works through the payments one
// by one on the one shared multiplier. Operation 0 costs one evaluation, operation 1 between
// one and iteration_limit + 2. The block takes one item at a time; in_ready is high only
// while no item is in work, and a finished result waits in the output register until
// taken. Configuration writes are always accepted and should be made while the block
// is idle.
module bond_price_and_yield_bisection import bpyb_pkg::*; #(
	parameter int MAX_PAYMENTS = MaxPaymentsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [PriceW-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              operation,
	input  wire logic [YieldW-1:0] yield_percent,
	input  wire logic [PriceW-1:0] market_price,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [PriceW-1:0]      bond_price,
	output logic [YieldW-1:0]      found_yield,
	output logic                   status
);

	typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_OUT} state_t;
	typedef enum logic [1:0] {PH_OP0, PH_LOW, PH_HIGH, PH_MID} phase_t;

	// Configuration registers.
	price_cfg_t cfg_q;
	logic [31:0] tol_q;
	logic [7:0]  limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.face   <= 48'd6553600;
			cfg_q.coupon <= '0;
			cfg_q.count  <= 8'd1;
			tol_q        <= 32'd655;
			limit_q      <= 8'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FACE:   cfg_q.face   <= cfg_data;
				CFG_COUPON: cfg_q.coupon <= cfg_data;
				CFG_COUNT:  cfg_q.count  <= cfg_data[7:0];
				CFG_TOL:    tol_q        <= cfg_data[31:0];
				CFG_LIMIT:  limit_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	state_t            state_q;
	phase_t            phase_q;
	logic [YieldW-1:0] yin_q;
	logic [PriceW-1:0] tgt_q;
	logic [YieldW-1:0] lo_q;
	logic [YieldW-1:0] hi_q;
	logic [YieldW-1:0] eval_y_q;
	logic [7:0]        k_q;
	logic [PriceW-1:0] res_price_q;
	logic [YieldW-1:0] res_yield_q;
	logic              res_status_q;
	logic              out_valid_q;
	logic [PriceW-1:0] out_price_q;
	logic [YieldW-1:0] out_yield_q;
	logic              out_status_q;

	logic              price_done;
	logic [PriceW-1:0] price_val;
	logic              price_start;

	assign price_start = (state_q == S_START);

	bpyb_price #(
		.MAX_PAYMENTS (MAX_PAYMENTS)
	) u_price (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (price_start),
		.yield_in (eval_y_q),
		.cfg      (cfg_q),
		.done     (price_done),
		.price    (price_val)
	);

	// Decision logic on a finished evaluation.
	logic [PriceW-1:0] gap;
	logic              close;
	logic              above;
	logic              narrow;
	logic [YieldW-1:0] nlo;
	logic [YieldW-1:0] nhi;
	logic [YieldW-1:0] cur_mid;
	logic [YieldW-1:0] next_mid;
	logic [8:0]        k_next;

	always_comb begin
		above    = price_val > tgt_q;
		gap      = above ? price_val - tgt_q : tgt_q - price_val;
		close    = gap <= {16'd0, tol_q};
		narrow   = {9'd0, hi_q - lo_q} <= {tol_q, 8'd0};
		nlo      = above ? eval_y_q : lo_q;
		nhi      = above ? hi_q : eval_y_q;
		cur_mid  = YieldW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
		next_mid = YieldW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
		k_next   = {1'b0, k_q} + 9'd1;
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_OP0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					yin_q   <= yield_percent;
					tgt_q   <= market_price;
					lo_q    <= '0;
					hi_q    <= YieldFull;
					k_q     <= '0;
					phase_q <= operation ? PH_LOW : PH_OP0;
					eval_y_q <= operation ? '0 : yield_percent;
					state_q <= S_START;
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: if (price_done) begin
					// Any branch that neither succeeds nor continues reports a failure.
					unique case (phase_q)
						PH_OP0: begin
							res_price_q  <= price_val;
							res_yield_q  <= yin_q;
							res_status_q <= 1'b0;
							state_q      <= S_OUT;
						end
						PH_LOW: begin
							if (close) begin
								res_price_q  <= price_val;
								res_yield_q  <= '0;
								res_status_q <= 1'b0;
								state_q      <= S_OUT;
							end else if (!(price_val < tgt_q)) begin
								eval_y_q <= YieldFull;
								phase_q  <= PH_HIGH;
								state_q  <= S_START;
							end else begin
								res_price_q  <= '0;
								res_yield_q  <= '0;
								res_status_q <= 1'b1;
								state_q      <= S_OUT;
							end
						end
						PH_HIGH: begin
							if (close) begin
								res_price_q  <= price_val;
								res_yield_q  <= YieldFull;
								res_status_q <= 1'b0;
								state_q      <= S_OUT;
							end else if (!above && limit_q != '0) begin
								eval_y_q <= cur_mid;
								phase_q  <= PH_MID;
								state_q  <= S_START;
							end else begin
								res_price_q  <= '0;
								res_yield_q  <= '0;
								res_status_q <= 1'b1;
								state_q      <= S_OUT;
							end
						end
						PH_MID: begin
							if (close || narrow) begin
								res_price_q  <= price_val;
								res_yield_q  <= eval_y_q;
								res_status_q <= 1'b0;
								state_q      <= S_OUT;
							end else if (k_next < {1'b0, limit_q}) begin
								lo_q     <= nlo;
								hi_q     <= nhi;
								k_q      <= k_next[7:0];
								eval_y_q <= next_mid;
								state_q  <= S_START;
							end else begin
								res_price_q  <= '0;
								res_yield_q  <= '0;
								res_status_q <= 1'b1;
								state_q      <= S_OUT;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_OUT: if (!out_valid_q || out_ready) begin
					out_valid_q  <= 1'b1;
					out_price_q  <= res_price_q;
					out_yield_q  <= res_yield_q;
					out_status_q <= res_status_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign bond_price  = out_price_q;
	assign found_yield = out_yield_q;
	assign status      = out_status_q;

	// A failed search never carries a price or a yield.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> bond_price == '0 && found_yield == '0)
		else $error("failure result carries nonzero fields");

	// The price unit finishes only while the sequencer waits for it.
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		price_done |-> state_q == S_WAIT)
		else $error("price unit finished outside the wait state");

	// An accepted item blocks the input until its result is out.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting an item");

	// The search interval never inverts.
	a_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> lo_q <= hi_q)
		else $error("bisection interval inverted");

endmodule
`default_nettype wire

### verif/bpyb_checker.sv
`default_nettype none
// Watches the configuration, input and output channels of the bond calculator. It keeps
// its own copy of the registers and works out the result of every accepted item.
module bpyb_checker import bpyb_pkg::*; #(
	parameter int MAX_PAYMENTS = MaxPaymentsDef
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [PriceW-1:0] cfg_data,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic              operation,
	input  wire logic [YieldW-1:0] yield_percent,
	input  wire logic [PriceW-1:0] market_price,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [PriceW-1:0] bond_price,
	input  wire logic [YieldW-1:0] found_yield,
	input  wire logic              status,
	output int                     fails,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] DfOne = 64'h1_0000_0000;
	localparam logic [63:0] PriceMax = 64'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [YieldW-1:0] yld;
		logic              st;
	} quote_t;

	logic [63:0] face_q, coupon_q, count_q, tol_q, limit_q;
	quote_t quotes_due[$];

	function automatic logic [63:0] period_factor(logic [63:0] y);
		logic [63:0] den;
		den = DenBase + y;
		return ((DenBase << 32) + (den >> 1)) / den;
	endfunction

	function automatic logic [63:0] price_at_yield(logic [63:0] y);
		logic [63:0] d, p, total, cf, n;
		d = period_factor(y);
		p = DfOne;
		total = 0;
		n = (count_q > MAX_PAYMENTS) ? 64'(MAX_PAYMENTS) : count_q;
		for (longint unsigned i = 1; i <= n; i++) begin
			if (d < DfOne)
				p = (p * d + 64'h8000_0000) >> 32;
			cf = (i < n) ? coupon_q : (face_q << 1) + coupon_q;
			total += (cf >> 32) * p + (((cf & 64'hFFFF_FFFF) * p + 64'h8000_0000) >> 32);
		end
		total = (total + 1) >> 1;
		return (total > PriceMax) ? PriceMax : total;
	endfunction

	function automatic logic [63:0] price_gap(logic [63:0] a, logic [63:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic quote_t solve_quote(logic op, logic [63:0] y, logic [63:0] target);
		quote_t q;
		logic [63:0] lo, hi, mid, b;
		q = '{price: '0, yld: '0, st: 1'b1};
		if (!op) begin
			q.price = price_at_yield(y);
			q.yld = y[YieldW-1:0];
			q.st = 1'b0;
			return q;
		end
		lo = 0;
		hi = 64'(YieldFull);
		b = price_at_yield(lo);
		if (price_gap(b, target) <= tol_q) begin
			q = '{price: b[PriceW-1:0], yld: '0, st: 1'b0};
			return q;
		end
		if (b < target)
			return q;
		b = price_at_yield(hi);
		if (price_gap(b, target) <= tol_q) begin
			q = '{price: b[PriceW-1:0], yld: YieldFull, st: 1'b0};
			return q;
		end
		if (b > target)
			return q;
		for (longint unsigned k = 0; k < limit_q; k++) begin
			mid = (lo + hi) >> 1;
			b = price_at_yield(mid);
			if (price_gap(b, target) <= tol_q || hi - lo <= (tol_q << 8)) begin
				q = '{price: b[PriceW-1:0], yld: mid[YieldW-1:0], st: 1'b0};
				return q;
			end
			if (b > target)
				lo = mid;
			else
				hi = mid;
		end
		return q;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quote_t want;
		if (!arst_n) begin
			face_q = 64'd6553600;
			coupon_q = 0;
			count_q = 1;
			tol_q = 655;
			limit_q = 64;
			fails = 0;
			quotes_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_FACE: face_q = 64'(cfg_data);
					CFG_COUPON: coupon_q = 64'(cfg_data);
					CFG_COUNT: count_q = 64'(cfg_data[7:0]);
					CFG_TOL: tol_q = 64'(cfg_data[31:0]);
					CFG_LIMIT: limit_q = 64'(cfg_data[7:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				quotes_due.push_back(solve_quote(operation, 64'(yield_percent),
					64'(market_price)));
			if (out_valid && out_ready) begin
				if (quotes_due.size() == 0) begin
					$display("%0t: result with none expected, price %0d yield %0d status %0d",
						$time, bond_price, found_yield, status);
					fails++;
				end else begin
					want = quotes_due.pop_front();
					if (bond_price !== want.price) begin
						$display("%0t: bond_price expected %0d actual %0d",
							$time, want.price, bond_price);
						fails++;
					end
					if (found_yield !== want.yld) begin
						$display("%0t: found_yield expected %0d actual %0d",
							$time, want.yld, found_yield);
						fails++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						fails++;
					end
				end
			end
		end
		pending = quotes_due.size();
	end

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// Top of the bond calculator testbench. It resets the block, runs a list of register
// settings and sends price and yield requests under each one. All checking happens in
// the checker instance; this module drives the channels, watches for a hang and gives the verdict.
module tb_top;
	import bpyb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Nothing accepted on any channel for this many cycles means the block hung. The
	// slowest item is a full bisection over many payments, well below this.
	localparam int StallLimit = 400000;
	localparam logic [2:0] CfgUnused = 3'd7;
	localparam logic [PriceW-1:0] PriceTop = '1;
	localparam logic [YieldW-1:0] YieldTop = '1;
	localparam logic [PriceW-1:0] Dollar = 48'd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [PriceW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic operation = 1'b0;
	logic [YieldW-1:0] yield_percent = '0;
	logic [PriceW-1:0] market_price = '0;
	logic out_ready = 1'b0;
	logic cfg_ready, in_ready, out_valid, status;
	logic [PriceW-1:0] bond_price;
	logic [YieldW-1:0] found_yield;
	int fails, pending;
	int quiet_cycles = 0;

	// calm turns off idling on both sides near the end of the run; hold_out asks the
	// receiver for one long stall so that the block backs up into its input.
	bit calm = 1'b0;
	bit hold_out = 1'b0;

	// Register set used while the current phase runs, kept here to aim targets.
	logic [63:0] cur_face = 64'd6553600, cur_coupon = 0, cur_count = 1;

	typedef struct {
		logic [PriceW-1:0] face;
		logic [PriceW-1:0] coupon;
		logic [7:0] count;
		logic [31:0] tol;
		logic [7:0] limit;
		int items;
	} phase_t;

	phase_t phases[6];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bond_price_and_yield_bisection i_dut (.*);

	bpyb_checker i_checker (.*);

	// Watchdog: any accepted item or register write resets the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random bursts of ready and of stall, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// A register write does not drop valid afterwards, so that back-to-back writes keep it
	// high; the caller lowers it once the whole set is written.
	task automatic write_reg(logic [2:0] idx, logic [PriceW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Sends one item; an optional gap in front of it drops valid for a random burst.
	task automatic send_item(logic op, logic [YieldW-1:0] y, logic [PriceW-1:0] target);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		yield_percent <= y;
		market_price <= target;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Lets every expected result come out before the registers change. The first edge
	// gives the checker time to count an item accepted at the edge just passed.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [PriceW-1:0] rand_price();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[PriceW-1:0];
	endfunction

	// Rough price at zero yield: face plus all coupons. Targets drawn up to an eighth above it mostly
	// land inside the bracket, so the bisection gets real work.
	function automatic logic [PriceW-1:0] aimed_price();
		logic [63:0] n, ceiling, r;
		n = (cur_count > MaxPaymentsDef) ? 64'(MaxPaymentsDef) : cur_count;
		ceiling = cur_face + ((cur_coupon * n) >> 1);
		if (ceiling > 64'(PriceTop))
			ceiling = 64'(PriceTop);
		r = {$urandom, $urandom};
		return PriceW'(r % (ceiling + (ceiling >> 3) + 1));
	endfunction

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			send_item(1'b1, YieldW'($urandom), aimed_price());
		else if (pick < 7)
			send_item(1'b1, YieldW'($urandom), rand_price());
		else if (pick < 9)
			send_item(1'b0, YieldW'($urandom_range(0, int'(YieldFull))), rand_price());
		else
			send_item(1'b0, YieldW'($urandom), rand_price());
	endtask

	initial begin
		// Register settings, each run with random items. The extremes sit in the middle
		// phases with few items, since some of them make every bisection step costly.
		phases[0] = '{48'd1000 * Dollar, 48'd50 * Dollar, 8'd20, 32'd655, 8'd64, 22};
		phases[1] = '{PriceTop, PriceTop, 8'd255, 32'hFFFF_FFFF, 8'd8, 6};
		phases[2] = '{48'd0, 48'd0, 8'd0, 32'd0, 8'd0, 8};
		phases[3] = '{48'd100 * Dollar, 48'd6 * Dollar, 8'd10, 32'd0, 8'd255, 8};
		phases[4] = '{48'd500 * Dollar, 48'd30 * Dollar, 8'd128, 32'd65536, 8'd40, 8};
		phases[5] = '{48'd100 * Dollar, 48'd8 * Dollar, 8'd6, 32'd100, 8'd64, 48};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset registers: a 100 dollar face, no coupon and
		// one payment. Operation 0 at zero yield, at 100 percent and at the largest
		// 31-bit yield; then searches that hit the low end, hit the high end, fall
		// below and above the bracket, and one that needs a real bisection.
		send_item(1'b0, '0, '0);
		send_item(1'b0, YieldFull, PriceTop);
		send_item(1'b0, YieldTop, '0);
		send_item(1'b0, 31'd33554432, rand_price());
		send_item(1'b1, '0, 48'd6553600);
		send_item(1'b1, YieldTop, 48'd6553700);
		send_item(1'b1, '0, 48'd4369067);
		send_item(1'b1, '0, '0);
		send_item(1'b1, '0, PriceTop);
		send_item(1'b1, '0, 48'd5000000);
		send_item(1'b1, '0, 48'd4369067 + 48'd700);
		send_item(1'b1, '0, 48'd6553600 - 48'd655);
		send_item(1'b1, '0, 48'd6553600 - 48'd656);
		send_item(1'b1, '0, 48'd6553600 + 48'd656);
		for (int i = 0; i < 6; i++)
			random_item();

		foreach (phases[p]) begin
			drain();
			write_reg(CFG_FACE, phases[p].face);
			write_reg(CFG_COUPON, phases[p].coupon);
			write_reg(CFG_COUNT, 48'(phases[p].count));
			write_reg(CFG_TOL, 48'(phases[p].tol));
			write_reg(CFG_LIMIT, 48'(phases[p].limit));
			// An index past the register list must leave every register alone.
			if (p == 0)
				write_reg(CfgUnused, PriceTop);
			cfg_valid <= 1'b0;
			cur_face = 64'(phases[p].face);
			cur_coupon = 64'(phases[p].coupon);
			cur_count = 64'(phases[p].count);
			@(posedge clk);
			// In the last phase the receiver stalls for a long stretch while items
			// keep coming, and the final items run with no idling at all.
			if (p == 5)
				hold_out = 1'b1;
			for (int i = 0; i < phases[p].items; i++) begin
				if (p == 5 && i >= phases[p].items - 18)
					calm = 1'b1;
				random_item();
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
